FILE: rtl/ppa_pkg.sv
// ppa_pkg: shared types, codes and helpers for the packed pixel palette access block.
// No dependencies.
`timescale 1ns / 1ps

package ppa_pkg;

	typedef enum logic [1:0] {
		ACT_READ,
		ACT_WR_RGB,
		ACT_WR_IDX,
		ACT_WR_PAL
	} act_t;

	typedef enum logic [1:0] {
		MODE_1BPP,
		MODE_4BPP,
		MODE_8BPP,
		MODE_24BPP
	} mode_t;

	typedef enum logic [3:0] {
		S_CLR,
		S_IDLE,
		S_CALC,
		S_MUL,
		S_CHK,
		S_R3,
		S_R3D,
		S_W3,
		S_PRD,
		S_PDAT,
		S_SEL,
		S_SRCH,
		S_PUT,
		S_PALRD,
		S_PALD,
		S_DONE
	} state_t;

	// search unit status towards the sequencer
	typedef struct packed {
		logic rd_en;
		logic done;
	} near_sts_t;

	localparam logic [1:0] STS_OK    = 2'd0;
	localparam logic [1:0] STS_RANGE = 2'd1;
	localparam logic [1:0] STS_DEPTH = 2'd2;

	localparam logic [1:0] CFG_MODE   = 2'd0;
	localparam logic [1:0] CFG_WIDTH  = 2'd1;
	localparam logic [1:0] CFG_HEIGHT = 2'd2;
	localparam logic [1:0] CFG_COLORS = 2'd3;

	localparam logic [12:0] RST_WIDTH  = 13'd256;
	localparam logic [12:0] RST_HEIGHT = 13'd256;
	localparam logic [8:0]  RST_COLORS = 9'd16;

	function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
		abs_diff = (a > b) ? (a - b) : (b - a);
	endfunction

endpackage

FILE: rtl/ppa_ram.sv
// ppa_ram: generic single-port RAM, one write or read per cycle, registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ppa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

FILE: rtl/ppa_near.sv
// ppa_near: nearest palette colour search, one entry per cycle over the palette RAM.
// Depends on ppa_pkg.
`timescale 1ns / 1ps

module ppa_near import ppa_pkg::*; #(
	parameter int PALETTE_ENTRIES = 256
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [8:0]                         n,
	input  logic [7:0]                         r,
	input  logic [7:0]                         g,
	input  logic [7:0]                         b,
	input  logic [23:0]                        pal_col,
	output logic [$clog2(PALETTE_ENTRIES)-1:0] pal_addr,
	output near_sts_t                          sts,
	output logic [7:0]                         best
);

	localparam int PAW = $clog2(PALETTE_ENTRIES);

	logic       busy_q;
	logic [8:0] cnt_q;
	logic [8:0] lim_q;
	logic       vld_s1;
	logic [7:0] idx_s1;
	logic [7:0] best_q;
	logic [9:0] bestd_q;
	logic [8:0] n_clamp;
	logic [8:0] n_lim;
	logic [9:0] sad;
	logic       issue;

	always_comb begin
		n_clamp = (n > 9'(PALETTE_ENTRIES)) ? 9'(PALETTE_ENTRIES) : n;
		n_lim   = (n_clamp == 9'd0) ? 9'd1 : n_clamp;
		sad     = 10'(abs_diff(pal_col[23:16], r)) + 10'(abs_diff(pal_col[15:8], g))
		        + 10'(abs_diff(pal_col[7:0], b));
		issue   = busy_q && (cnt_q < lim_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			cnt_q   <= '0;
			lim_q   <= 9'd1;
			vld_s1  <= 1'b0;
			bestd_q <= '1;
		end else if (start) begin
			busy_q  <= 1'b1;
			cnt_q   <= '0;
			lim_q   <= n_lim;
			vld_s1  <= 1'b0;
			bestd_q <= '1;
		end else if (busy_q) begin
			vld_s1 <= issue;
			if (issue) begin
				cnt_q <= cnt_q + 9'd1;
			end
			if (vld_s1 && (sad < bestd_q)) begin
				bestd_q <= sad;
			end
			if (!issue && !vld_s1) begin
				busy_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (start) begin
			best_q <= '0;
		end else begin
			if (issue) begin
				idx_s1 <= cnt_q[7:0];
			end
			if (busy_q && vld_s1 && (sad < bestd_q)) begin
				best_q <= idx_s1;
			end
		end
	end

	assign pal_addr  = cnt_q[PAW-1:0];
	assign sts.rd_en = issue;
	assign sts.done  = busy_q && !issue && !vld_s1;
	assign best      = best_q;

endmodule

FILE: rtl/packed_pixel_palette_access.sv
// packed_pixel_palette_access: top level, sequencer, address unit and result register.
// Depends on ppa_pkg, ppa_ram, ppa_near.
`timescale 1ns / 1ps

// Pixel access port for a bottom-up packed bitmap (1, 4, 8 or 24 bpp) with a palette.
// Input channel: in_valid / in_stall, one item is an access (read, write by RGB,
// write by index, palette write). Output channel: out_valid / out_stall, exactly
// one result item per input item, in order.
// Configuration: cfg_we / cfg_index / cfg_data, to be written by the user only while
// idle; the block itself does not enforce this. Pixel accesses compute the address
// and check it against the store; a 24 bpp access then moves its three bytes, others
// read the packed byte, write the new index back on a write and read the palette for
// the colour. An RGB write takes its index from the search unit, which reads one
// palette entry per cycle from the single-port palette RAM over n entries, n =
// colors_used clamped to 1..PALETTE_ENTRIES. One item at a time: in_stall is high
// from acceptance until the result is loaded into the output register.
// Reset: the pixel RAM is swept to zero, one byte per cycle, all STORE_BYTES bytes
// (65536 by default) with in_stall high; palette entries read as black until
// written (per-entry valid flops cleared at reset).
// A stalled result stays in the output register; the next item can be accepted
// meanwhile but its result waits until the register is free.

module packed_pixel_palette_access import ppa_pkg::*; #(
	parameter int STORE_BYTES     = 65536,
	parameter int PALETTE_ENTRIES = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [12:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  action,
	input  logic [11:0] pos_x,
	input  logic [11:0] pos_y,
	input  logic [7:0]  in_red,
	input  logic [7:0]  in_green,
	input  logic [7:0]  in_blue,
	input  logic [7:0]  color_index,
	input  logic [7:0]  palette_slot,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_red,
	output logic [7:0]  out_green,
	output logic [7:0]  out_blue,
	output logic [7:0]  out_index,
	output logic [1:0]  status
);

	localparam int AW  = $clog2(STORE_BYTES);
	localparam int PAW = $clog2(PALETTE_ENTRIES);
	localparam int PSZ = 1 << PAW;
	localparam logic [29:0] STORE_LIM = 30'(STORE_BYTES);

	// config
	mode_t       mode_q;
	logic [12:0] width_q;
	logic [12:0] height_q;
	logic [8:0]  colors_q;

	// item
	act_t        act_q;
	logic [11:0] x_q;
	logic [11:0] y_q;
	logic [7:0]  r_q;
	logic [7:0]  g_q;
	logic [7:0]  b_q;
	logic [7:0]  cidx_q;
	logic [7:0]  slot_q;

	state_t      state_q, state_d;

	logic [15:0] stride_q;
	logic [12:0] row_q;
	logic [13:0] boff_q;
	logic [29:0] addr_q;
	logic [1:0]  k_q;
	logic [7:0]  byte_q;
	logic [7:0]  idx_q;
	logic [23:0] res_col_q;
	logic [7:0]  res_idx_q;
	logic [1:0]  res_sts_q;
	logic [AW-1:0] clr_q;
	logic [PSZ-1:0] pal_vld_q;
	logic        pal_vld_s1;

	logic        out_valid_q;
	logic [23:0] out_col_q;
	logic [7:0]  out_idx_q;
	logic [1:0]  out_sts_q;

	// datapath helpers
	logic [17:0] bits_w;
	logic [18:0] str_sum;
	logic [15:0] stride_d;
	logic [13:0] boff_d;
	logic [12:0] row_d;
	logic        oor;
	logic [29:0] last;
	logic [2:0]  sh;
	logic [7:0]  fmask;
	logic [7:0]  byte_new;
	logic [7:0]  rd_idx;
	logic [7:0]  wr_idx;
	logic        slot_ok;
	logic        idx_ok;
	logic [23:0] pal_col;
	logic        load_out;

	// RAM ports
	logic          px_we;
	logic [AW-1:0] px_addr;
	logic [7:0]    px_wdata;
	logic [7:0]    px_rdata;
	logic          pal_we;
	logic [PAW-1:0] pal_addr;
	logic [23:0]   pal_rdata;

	// search unit
	logic          near_start;
	logic [PAW-1:0] near_addr;
	near_sts_t     near_sts;
	logic [7:0]    near_best;

	always_comb begin
		case (mode_q)
			MODE_1BPP:  bits_w = {5'b0, width_q};
			MODE_4BPP:  bits_w = {3'b0, width_q, 2'b0};
			MODE_8BPP:  bits_w = {2'b0, width_q, 3'b0};
			MODE_24BPP: bits_w = {1'b0, width_q, 4'b0} + {2'b0, width_q, 3'b0};
			default:    bits_w = {5'b0, width_q};
		endcase
		str_sum  = {1'b0, bits_w} + 19'd31;
		stride_d = {str_sum[18:5], 2'b00};
		case (mode_q)
			MODE_1BPP:  boff_d = 14'(x_q >> 3);
			MODE_4BPP:  boff_d = 14'(x_q >> 1);
			MODE_8BPP:  boff_d = {2'b0, x_q};
			MODE_24BPP: boff_d = {2'b0, x_q} + {1'b0, x_q, 1'b0};
			default:    boff_d = {2'b0, x_q};
		endcase
		row_d = height_q - 13'd1 - {1'b0, y_q};
		oor   = ({1'b0, x_q} >= width_q) || ({1'b0, y_q} >= height_q);
		last  = addr_q + ((mode_q == MODE_24BPP) ? 30'd2 : 30'd0);
		// sub-byte packing: leftmost pixel in the most significant bits
		case (mode_q)
			MODE_1BPP: begin
				sh    = 3'd7 - x_q[2:0];
				fmask = 8'h01;
			end
			MODE_4BPP: begin
				sh    = x_q[0] ? 3'd0 : 3'd4;
				fmask = 8'h0F;
			end
			default: begin
				sh    = 3'd0;
				fmask = 8'hFF;
			end
		endcase
		byte_new = (byte_q & ~(fmask << sh)) | (idx_q << sh);
		rd_idx   = (byte_q >> sh) & fmask;
		wr_idx   = (mode_q == MODE_1BPP) ? {7'b0, |cidx_q} : (cidx_q & fmask);
		slot_ok  = {1'b0, slot_q} < 9'(PALETTE_ENTRIES);
		idx_ok   = {1'b0, idx_q} < 9'(PALETTE_ENTRIES);
		pal_col  = pal_vld_s1 ? pal_rdata : 24'd0;
		load_out = !out_valid_q || !out_stall;
	end

	// next state and RAM control
	always_comb begin
		state_d    = state_q;
		px_we      = 1'b0;
		px_addr    = addr_q[AW-1:0];
		px_wdata   = byte_new;
		pal_we     = 1'b0;
		pal_addr   = near_addr;
		near_start = 1'b0;
		in_stall   = 1'b1;
		case (state_q)
			S_CLR: begin
				px_we    = 1'b1;
				px_addr  = clr_q;
				px_wdata = 8'd0;
				if (clr_q == AW'(STORE_BYTES - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_d = S_CALC;
				end
			end
			S_CALC: begin
				pal_addr = slot_q[PAW-1:0];
				if (act_q == ACT_WR_PAL) begin
					pal_we  = slot_ok;
					state_d = S_DONE;
				end else if ((act_q == ACT_WR_IDX) && (mode_q == MODE_24BPP)) begin
					state_d = S_DONE;
				end else if (oor) begin
					state_d = S_DONE;
				end else begin
					state_d = S_MUL;
				end
			end
			S_MUL: state_d = S_CHK;
			S_CHK: begin
				if (last >= STORE_LIM) begin
					state_d = S_DONE;
				end else if (mode_q == MODE_24BPP) begin
					state_d = (act_q == ACT_READ) ? S_R3 : S_W3;
				end else begin
					state_d = S_PRD;
				end
			end
			S_R3: begin
				px_addr = addr_q[AW-1:0] + AW'(k_q);
				state_d = S_R3D;
			end
			S_R3D: state_d = (k_q == 2'd2) ? S_DONE : S_R3;
			S_W3: begin
				// bytes in memory order B, G, R
				px_we   = 1'b1;
				px_addr = addr_q[AW-1:0] + AW'(k_q);
				case (k_q)
					2'd0:    px_wdata = b_q;
					2'd1:    px_wdata = g_q;
					default: px_wdata = r_q;
				endcase
				if (k_q == 2'd2) begin
					state_d = S_DONE;
				end
			end
			S_PRD:  state_d = S_PDAT;
			S_PDAT: state_d = S_SEL;
			S_SEL: begin
				case (act_q)
					ACT_READ:   state_d = S_PALRD;
					ACT_WR_RGB: begin
						near_start = 1'b1;
						state_d    = S_SRCH;
					end
					default:    state_d = S_PUT;
				endcase
			end
			S_SRCH: begin
				if (near_sts.done) begin
					state_d = S_PUT;
				end
			end
			S_PUT: begin
				px_we   = 1'b1;
				state_d = S_PALRD;
			end
			S_PALRD: begin
				pal_addr = idx_q[PAW-1:0];
				state_d  = S_PALD;
			end
			S_PALD: state_d = S_DONE;
			S_DONE: begin
				if (load_out) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_4BPP;
			width_q  <= RST_WIDTH;
			height_q <= RST_HEIGHT;
			colors_q <= RST_COLORS;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MODE:   mode_q   <= mode_t'(cfg_data[1:0]);
				CFG_WIDTH:  width_q  <= cfg_data;
				CFG_HEIGHT: height_q <= cfg_data;
				CFG_COLORS: colors_q <= cfg_data[8:0];
				default:    mode_q   <= mode_q;
			endcase
		end
	end

	// control: clear sweep, palette valid bits, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			pal_vld_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_CLR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (pal_we) begin
				pal_vld_q[slot_q[PAW-1:0]] <= 1'b1;
			end
			if ((state_q == S_DONE) && load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		pal_vld_s1 <= pal_vld_q[pal_addr];
		case (state_q)
			S_IDLE: begin
				act_q  <= act_t'(action);
				x_q    <= pos_x;
				y_q    <= pos_y;
				r_q    <= in_red;
				g_q    <= in_green;
				b_q    <= in_blue;
				cidx_q <= color_index;
				slot_q <= palette_slot;
			end
			S_CALC: begin
				stride_q  <= stride_d;
				row_q     <= row_d;
				boff_q    <= boff_d;
				k_q       <= 2'd0;
				if ((act_q == ACT_WR_PAL) && slot_ok) begin
					res_col_q <= {r_q, g_q, b_q};
					res_idx_q <= slot_q;
					res_sts_q <= STS_OK;
				end else begin
					res_col_q <= 24'd0;
					res_idx_q <= 8'd0;
					if (act_q == ACT_WR_PAL) begin
						res_sts_q <= STS_RANGE;
					end else if ((act_q == ACT_WR_IDX) && (mode_q == MODE_24BPP)) begin
						res_sts_q <= STS_DEPTH;
					end else if (oor) begin
						res_sts_q <= STS_RANGE;
					end else begin
						res_sts_q <= STS_OK;
					end
				end
			end
			S_MUL: addr_q <= 30'(row_q) * 30'(stride_q) + 30'(boff_q);
			S_CHK: begin
				if (last >= STORE_LIM) begin
					res_sts_q <= STS_RANGE;
				end
			end
			S_R3D: begin
				case (k_q)
					2'd0:    res_col_q[7:0]   <= px_rdata;
					2'd1:    res_col_q[15:8]  <= px_rdata;
					default: res_col_q[23:16] <= px_rdata;
				endcase
				k_q <= k_q + 2'd1;
			end
			S_W3: begin
				k_q       <= k_q + 2'd1;
				res_col_q <= {r_q, g_q, b_q};
			end
			S_PDAT: byte_q <= px_rdata;
			S_SEL: begin
				if (act_q == ACT_READ) begin
					idx_q <= rd_idx;
				end else begin
					idx_q <= wr_idx;
				end
			end
			S_SRCH: begin
				if (near_sts.done) begin
					idx_q <= near_best & fmask;
				end
			end
			S_PALD: begin
				res_col_q <= idx_ok ? pal_col : 24'd0;
				res_idx_q <= idx_q;
			end
			S_DONE: begin
				if (load_out) begin
					out_col_q <= res_col_q;
					out_idx_q <= res_idx_q;
					out_sts_q <= res_sts_q;
				end
			end
			default: byte_q <= byte_q;
		endcase
	end

	ppa_ram #(
		.WIDTH (8),
		.DEPTH (STORE_BYTES)
	) u_px_ram (
		.clk   (clk),
		.we    (px_we),
		.addr  (px_addr),
		.wdata (px_wdata),
		.rdata (px_rdata)
	);

	ppa_ram #(
		.WIDTH (24),
		.DEPTH (PALETTE_ENTRIES)
	) u_pal_ram (
		.clk   (clk),
		.we    (pal_we),
		.addr  (pal_addr),
		.wdata ({r_q, g_q, b_q}),
		.rdata (pal_rdata)
	);

	ppa_near #(
		.PALETTE_ENTRIES (PALETTE_ENTRIES)
	) u_near (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (near_start),
		.n        (colors_q),
		.r        (r_q),
		.g        (g_q),
		.b        (b_q),
		.pal_col  (pal_col),
		.pal_addr (near_addr),
		.sts      (near_sts),
		.best     (near_best)
	);

	assign out_valid = out_valid_q;
	assign out_red   = out_col_q[23:16];
	assign out_green = out_col_q[15:8];
	assign out_blue  = out_col_q[7:0];
	assign out_index = out_idx_q;
	assign status    = out_sts_q;

endmodule

FILE: rtl/ppa_chk.sv
// ppa_chk: port-level checks for packed_pixel_palette_access, with its bind.
// Depends on ppa_pkg.
`timescale 1ns / 1ps

module ppa_chk import ppa_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] out_red,
	input logic [7:0] out_green,
	input logic [7:0] out_blue,
	input logic [7:0] out_index,
	input logic [1:0] status
);

	// one item in flight: busy right after acceptance
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("item accepted while previous one still in work");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("stalled result dropped");

	a_sts: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == STS_OK || status == STS_RANGE || status == STS_DEPTH))
		else $error("undefined status code");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != STS_OK) |->
			(out_red == 8'd0) && (out_green == 8'd0) && (out_blue == 8'd0)
			&& (out_index == 8'd0))
		else $error("failed access returned nonzero payload");

endmodule

bind packed_pixel_palette_access ppa_chk u_ppa_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_red   (out_red),
	.out_green (out_green),
	.out_blue  (out_blue),
	.out_index (out_index),
	.status    (status)
);

FILE: dv/testbench.sv
// testbench: self-checking bench for packed_pixel_palette_access.
// Depends on ppa_pkg and the block's RTL; predicts each result and checks it in order.
`timescale 1ns / 1ps

module testbench;
	import ppa_pkg::*;

	localparam int STORE_BYTES     = 65536;
	localparam int PALETTE_ENTRIES = 256;
	localparam int DRAIN_CYCLES    = 320;     // longest RGB search plus margin
	localparam int STALL_LIMIT     = 200000;  // covers the store clear after reset

	typedef struct {
		act_t       act;
		logic [11:0] x, y;
		logic [7:0]  r, g, b, cidx, slot;
	} access_t;

	typedef struct {
		logic [7:0] r, g, b, idx;
		logic [1:0] sts;
	} pixel_result_t;

	logic        clk, arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [12:0] cfg_data;
	logic        in_valid, in_stall;
	logic [1:0]  action;
	logic [11:0] pos_x, pos_y;
	logic [7:0]  in_red, in_green, in_blue, color_index, palette_slot;
	logic        out_valid, out_stall;
	logic [7:0]  out_red, out_green, out_blue, out_index;
	logic [1:0]  status;

	packed_pixel_palette_access #(
		.STORE_BYTES(STORE_BYTES),
		.PALETTE_ENTRIES(PALETTE_ENTRIES)
	) dut (.*);

	// shadow copy of the block's state and registers
	logic [7:0]  shadow_pixels [STORE_BYTES];
	logic [23:0] shadow_palette [PALETTE_ENTRIES];
	mode_t       cur_mode;
	int unsigned cur_width, cur_height, cur_colors;

	pixel_result_t pending_results[$];
	int  mismatches;
	int  send_idle_pct, recv_stall_pct;
	int  quiet_cycles;

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	// nearest palette colour by sum of absolute channel differences, lowest index wins
	function automatic int unsigned nearest_entry(logic [7:0] r, logic [7:0] g, logic [7:0] b);
		int unsigned n, best, best_d, d;
		n = (cur_colors > PALETTE_ENTRIES) ? PALETTE_ENTRIES : cur_colors;
		if (n == 0) n = 1;
		best = 0;
		best_d = 32'hFFFF_FFFF;
		for (int unsigned i = 0; i < n; i++) begin
			d = abs_diff(shadow_palette[i][23:16], r) + abs_diff(shadow_palette[i][15:8], g)
				+ abs_diff(shadow_palette[i][7:0], b);
			if (d < best_d) begin
				best_d = d;
				best = i;
			end
		end
		return best;
	endfunction

	function automatic pixel_result_t compute_access(access_t a);
		pixel_result_t res;
		int unsigned bpp, sh, fmask, pix_idx;
		longint unsigned stride, addr, last;
		logic [7:0]  byte_val;
		logic [23:0] colour;
		res = '{default: '0};
		case (cur_mode)
			MODE_1BPP: bpp = 1;
			MODE_4BPP: bpp = 4;
			MODE_8BPP: bpp = 8;
			default:   bpp = 24;
		endcase
		if (a.act == ACT_WR_PAL) begin
			if (a.slot >= PALETTE_ENTRIES) begin
				res.sts = STS_RANGE;
				return res;
			end
			shadow_palette[a.slot] = {a.r, a.g, a.b};
			res.r = a.r; res.g = a.g; res.b = a.b; res.idx = a.slot;
			return res;
		end
		if (a.act == ACT_WR_IDX && cur_mode == MODE_24BPP) begin
			res.sts = STS_DEPTH;
			return res;
		end
		if (a.x >= cur_width || a.y >= cur_height) begin
			res.sts = STS_RANGE;
			return res;
		end
		stride = ((longint'(cur_width) * bpp + 31) / 32) * 4;
		addr = longint'(cur_height - 1 - a.y) * stride + (longint'(a.x) * bpp) / 8;
		last = addr + ((cur_mode == MODE_24BPP) ? 2 : 0);
		if (last >= STORE_BYTES) begin
			res.sts = STS_RANGE;
			return res;
		end
		if (cur_mode == MODE_24BPP) begin
			if (a.act == ACT_READ) begin
				colour = {shadow_pixels[addr + 2], shadow_pixels[addr + 1], shadow_pixels[addr]};
			end else begin
				shadow_pixels[addr]     = a.b;
				shadow_pixels[addr + 1] = a.g;
				shadow_pixels[addr + 2] = a.r;
				colour = {a.r, a.g, a.b};
			end
			{res.r, res.g, res.b} = colour;
			return res;
		end
		byte_val = shadow_pixels[addr];
		case (cur_mode)
			MODE_1BPP: begin sh = 7 - (a.x & 7); fmask = 'h1; end
			MODE_4BPP: begin sh = a.x[0] ? 0 : 4; fmask = 'h0F; end
			default:   begin sh = 0; fmask = 'hFF; end
		endcase
		if (a.act == ACT_READ) begin
			pix_idx = (byte_val >> sh) & fmask;
		end else begin
			if (a.act == ACT_WR_RGB)
				pix_idx = nearest_entry(a.r, a.g, a.b) & fmask;
			else if (cur_mode == MODE_1BPP)
				pix_idx = (a.cidx != 0) ? 1 : 0;
			else
				pix_idx = a.cidx & fmask;
			byte_val = 8'((byte_val & ~(fmask << sh)) | (pix_idx << sh));
			shadow_pixels[addr] = byte_val;
		end
		colour = (pix_idx < PALETTE_ENTRIES) ? shadow_palette[pix_idx] : 24'h0;
		{res.r, res.g, res.b} = colour;
		res.idx = 8'(pix_idx);
		return res;
	endfunction

	// receiver side: random stall, new value each falling edge
	always @(negedge clk)
		out_stall <= ($urandom_range(99) < recv_stall_pct);

	// result checker: oldest expectation against each accepted result item
	always @(posedge clk) begin
		pixel_result_t exp_res;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("result item with nothing expected");
				mismatches++;
			end else begin
				exp_res = pending_results.pop_front();
				if (out_red !== exp_res.r) begin
					$error("out_red expected %0d got %0d", exp_res.r, out_red);
					mismatches++;
				end
				if (out_green !== exp_res.g) begin
					$error("out_green expected %0d got %0d", exp_res.g, out_green);
					mismatches++;
				end
				if (out_blue !== exp_res.b) begin
					$error("out_blue expected %0d got %0d", exp_res.b, out_blue);
					mismatches++;
				end
				if (out_index !== exp_res.idx) begin
					$error("out_index expected %0d got %0d", exp_res.idx, out_index);
					mismatches++;
				end
				if (status !== exp_res.sts) begin
					$error("status expected %0d got %0d", exp_res.sts, status);
					mismatches++;
				end
			end
		end
	end

	// watchdog: ends the run after too long without any item moving
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// entered and left at a falling edge; predicts the result when accepted
	task automatic send_access(access_t a);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid     <= 1'b1;
		action       <= a.act;
		pos_x        <= a.x;
		pos_y        <= a.y;
		in_red       <= a.r;
		in_green     <= a.g;
		in_blue      <= a.b;
		color_index  <= a.cidx;
		palette_slot <= a.slot;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pending_results.push_back(compute_access(a));
		@(negedge clk);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending_results.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, int unsigned value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value[12:0];
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_MODE:   cur_mode = mode_t'(value[1:0]);
			CFG_WIDTH:  cur_width = value & 'h1FFF;
			CFG_HEIGHT: cur_height = value & 'h1FFF;
			default:    cur_colors = value & 'h1FF;
		endcase
	endtask

	task automatic configure(mode_t m, int unsigned w, int unsigned h, int unsigned n);
		wait_idle();
		write_reg(CFG_MODE, m);
		write_reg(CFG_WIDTH, w);
		write_reg(CFG_HEIGHT, h);
		write_reg(CFG_COLORS, n);
	endtask

	function automatic access_t make_access(act_t act, int x, int y, logic [23:0] rgb,
		logic [7:0] cidx, logic [7:0] slot);
		access_t a;
		a.act = act; a.x = 12'(x); a.y = 12'(y);
		{a.r, a.g, a.b} = rgb;
		a.cidx = cidx; a.slot = slot;
		return a;
	endfunction

	task automatic set_idling(int profile);
		case (profile % 4)
			0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
			default: begin send_idle_pct = 6; recv_stall_pct = 6; end
		endcase
	endtask

	// reset defaults: 4 bpp, 256 x 256, 16 colours
	task automatic test_directed();
		set_idling(0);
		send_access(make_access(ACT_READ, 0, 0, 24'h0, 8'h00, 8'h00));
		send_access(make_access(ACT_WR_PAL, 0, 0, 24'h000000, 8'h00, 8'h00));
		send_access(make_access(ACT_WR_PAL, 0, 0, 24'hFFFFFF, 8'h00, 8'hFF));
		send_access(make_access(ACT_WR_PAL, 0, 0, 24'hFF0000, 8'h00, 8'h0B));
		send_access(make_access(ACT_WR_PAL, 0, 0, 24'h10FF10, 8'h00, 8'h01));
		// even x sits in the high nibble
		send_access(make_access(ACT_WR_IDX, 0, 0, 24'h0, 8'hAB, 8'h00));
		send_access(make_access(ACT_READ, 0, 0, 24'h0, 8'h00, 8'h00));
		send_access(make_access(ACT_READ, 1, 0, 24'h0, 8'h00, 8'h00));
		send_access(make_access(ACT_WR_IDX, 255, 255, 24'h0, 8'hFF, 8'h00));
		send_access(make_access(ACT_READ, 255, 255, 24'h0, 8'h00, 8'h00));
		// nearest colour
		send_access(make_access(ACT_WR_RGB, 1, 0, 24'hF00808, 8'h00, 8'h00));
		send_access(make_access(ACT_WR_RGB, 2, 0, 24'h808080, 8'h00, 8'h00));
		send_access(make_access(ACT_READ, 1, 0, 24'h0, 8'h00, 8'h00));
		// out of range coordinates
		send_access(make_access(ACT_READ, 256, 0, 24'h0, 8'h00, 8'h00));
		send_access(make_access(ACT_WR_IDX, 0, 256, 24'h0, 8'h05, 8'h00));
		send_access(make_access(ACT_WR_RGB, 4095, 4095, 24'hFFFFFF, 8'h00, 8'h00));
		// index access at 24 bpp is refused, reads and RGB writes are not
		configure(MODE_24BPP, 256, 256, 16);
		send_access(make_access(ACT_WR_IDX, 0, 0, 24'h0, 8'h11, 8'h00));
		send_access(make_access(ACT_WR_RGB, 3, 2, 24'h123456, 8'h00, 8'h00));
		send_access(make_access(ACT_READ, 3, 2, 24'h0, 8'h00, 8'h00));
		send_access(make_access(ACT_WR_IDX, 4095, 0, 24'h0, 8'h11, 8'h00));
		// 1 bpp: any nonzero index stores one
		configure(MODE_1BPP, 9, 3, 2);
		send_access(make_access(ACT_WR_IDX, 8, 2, 24'h0, 8'h80, 8'h00));
		send_access(make_access(ACT_READ, 8, 2, 24'h0, 8'h00, 8'h00));
		send_access(make_access(ACT_READ, 7, 2, 24'h0, 8'h00, 8'h00));
	endtask

	function automatic access_t random_access();
		access_t a;
		int unsigned pick, xmax, ymax;
		pick = $urandom_range(99);
		a.act = (pick < 15) ? ACT_WR_PAL : (pick < 45) ? ACT_WR_RGB :
			(pick < 65) ? ACT_WR_IDX : ACT_READ;
		xmax = (cur_width > 4096) ? 4095 : cur_width - 1;
		ymax = (cur_height > 4096) ? 4095 : cur_height - 1;
		if ($urandom_range(99) < 12) begin
			a.x = 12'($urandom);
			a.y = 12'($urandom);
		end else begin
			a.x = 12'($urandom_range(xmax));
			// bottom image rows sit at the start of the store, so big images still fit
			if ($urandom_range(1))
				a.y = 12'(ymax - $urandom_range((ymax < 63) ? ymax : 63));
			else
				a.y = 12'($urandom_range(ymax));
		end
		a.r = 8'($urandom); a.g = 8'($urandom); a.b = 8'($urandom);
		a.cidx = $urandom_range(3) == 0 ? 8'h00 : 8'($urandom);
		a.slot = $urandom_range(1) ? 8'($urandom_range(15)) : 8'($urandom);
		return a;
	endfunction

	task automatic test_random_phase(int profile, mode_t m, int unsigned w, int unsigned h,
		int unsigned n, int unsigned count);
		configure(m, w, h, n);
		set_idling(profile);
		for (int unsigned i = 0; i < count; i++) begin
			// occasional switch to a stretch with no idling
			if (i == count / 2) set_idling(0);
			if (i == 3 * count / 4) set_idling(profile);
			send_access(random_access());
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
		in_valid = 1'b0; action = '0; pos_x = '0; pos_y = '0;
		in_red = '0; in_green = '0; in_blue = '0; color_index = '0; palette_slot = '0;
		out_stall = 1'b0;
		mismatches = 0; quiet_cycles = 0;
		send_idle_pct = 0; recv_stall_pct = 0;
		foreach (shadow_pixels[i]) shadow_pixels[i] = '0;
		foreach (shadow_palette[i]) shadow_palette[i] = '0;
		cur_mode = MODE_4BPP;
		cur_width = RST_WIDTH; cur_height = RST_HEIGHT; cur_colors = RST_COLORS;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed();
		test_random_phase(0, MODE_1BPP, 64, 40, 2, 160);
		test_random_phase(1, MODE_4BPP, 33, 17, 16, 160);
		test_random_phase(2, MODE_8BPP, 4096, 16, 256, 160);
		test_random_phase(3, MODE_24BPP, 1, 4096, 1, 160);
		test_random_phase(2, MODE_24BPP, 4096, 4096, 64, 160);
		test_random_phase(1, MODE_8BPP, 1, 1, 1, 160);
		test_random_phase(3, MODE_4BPP, 100, 100, 256, 160);
		test_random_phase(0, MODE_1BPP, 4096, 4096, 128, 160);

		wait_idle();
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
